// ===== rtl/core/vl2n_pkg.sv =====
// Shared types, constants and the seed-table helper functions for the L2 vector
// normalizer. No dependencies.
package vl2n_pkg;

    localparam int ElemW  = 16;
    localparam int SumW   = 37;
    localparam int YW     = 32;
    localparam int ItW    = 3;
    localparam logic [ItW-1:0] ItReset = 3'd3;

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_NORM  = 7'b0000010,
        ST_SEED  = 7'b0000100,
        ST_NSQ   = 7'b0001000,
        ST_NMUL  = 7'b0010000,
        ST_NUPD  = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    // Integer square root of a 64-bit value, one result bit per step.
    function automatic logic [31:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] b;
        rem = v;
        r   = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (b != 0) begin
                if (rem >= r + b) begin
                    rem = rem - (r + b);
                    r   = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r[31:0];
    endfunction

    // Square root of a seed bucket's center, scaled by 2^30.
    // Evaluated on constant indexes only, so it folds into a table.
    function automatic logic [63:0] seed_root(input int idx, input int sbits);
        logic [63:0] mid;
        mid = 64'((2 * idx + 1)) << (29 - sbits);
        return 64'(isqrt64(mid << 30));
    endfunction

endpackage

// ===== rtl/core/vl2n_store.sv =====
// Element memory of the L2 vector normalizer: one write port, one registered
// read port. Depends on vl2n_pkg.
module vl2n_store #(
    parameter int MAX_LEN = 64,
    parameter int AW      = 6
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [vl2n_pkg::ElemW-1:0]  i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [vl2n_pkg::ElemW-1:0]  o_rdata
);
    logic [vl2n_pkg::ElemW-1:0] mem [MAX_LEN];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== rtl/core/vl2n_scale.sv =====
// Output stage: element times inverse root, rounded and saturated to Q1.15.
// Two register stages. Depends on vl2n_pkg.
module vl2n_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [vl2n_pkg::ElemW-1:0]  i_elem,
    input  logic [vl2n_pkg::YW-1:0]     i_y,
    input  logic [5:0]                  i_shift,
    input  logic                        i_zero,
    input  logic                        i_last,
    input  logic                        i_trunc,
    output logic                        o_vld,
    output logic [vl2n_pkg::ElemW-1:0]  o_data,
    output logic                        o_last,
    output logic                        o_zero,
    output logic                        o_trunc
);
    logic [15:0] mag_in;
    logic [47:0] r_prod, n_prod;
    logic        r_neg, r_vld1, r_zero1, r_last1, r_trunc1;
    logic [5:0]  r_sh;
    logic [48:0] rnd;
    logic [48:0] q;
    logic [15:0] res;

    assign mag_in = i_elem[15] ? 16'(-i_elem) : i_elem;
    assign n_prod = 48'(mag_in) * 48'(i_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            o_vld  <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            o_vld  <= r_vld1;
        end
        r_prod   <= n_prod;
        r_neg    <= i_elem[15];
        r_sh     <= i_shift;
        r_zero1  <= i_zero;
        r_last1  <= i_last;
        r_trunc1 <= i_trunc;
        o_data   <= res;
        o_last   <= r_last1;
        o_zero   <= r_zero1;
        o_trunc  <= r_trunc1;
    end

    always_comb begin
        rnd = 49'(r_prod) + (49'd1 << (r_sh - 6'd1));
        q   = rnd >> r_sh;
        if (r_zero1) begin
            res = '0;
        end else if (r_neg) begin
            res = (q > 49'd32768) ? 16'h8000 : 16'(-q[15:0]);
        end else begin
            res = (q > 49'd32767) ? 16'h7FFF : q[15:0];
        end
    end
endmodule

// ===== rtl/core/vector_l2_normalizer_unit.sv =====
// Top level of the L2 vector normalizer: control sequencer, sum and Newton unit.
// Depends on vl2n_pkg, vl2n_store and vl2n_scale.
//
// Elements load one per cycle (busy stays low while loading). After the item
// marked last, busy rises for the inverse-root work (normalize, seed lookup,
// then square, multiply and update per Newton iteration, on one shared 32x34
// multiplier), then for emission: one result per cycle, delayed through the
// memory read register and the two register stages of the scaling multiplier.
// Results cannot be held off.
module vector_l2_normalizer_unit #(
    parameter int MAX_LEN   = 64,
    parameter int SEED_BITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_element,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [15:0] o_norm_element,
    output logic        o_last_res,
    output logic        o_zero_vector,
    output logic        o_truncated
);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SEEDN = 1 << SEED_BITS;

    logic [31:0] seed_tab [SEEDN];
    for (genvar g = 0; g < SEEDN; g++) begin : g_seed
        localparam logic [63:0] SeedQ = vl2n_pkg::seed_root(g, SEED_BITS);
        localparam logic [63:0] SeedS = (64'd1 << 60) / ((SeedQ == 64'd0) ? 64'd1 : SeedQ);
        assign seed_tab[g] = (SeedQ == 64'd0 || SeedS > 64'hFFFF_FFFF) ?
                             32'hFFFF_FFFF : SeedS[31:0];
    end

    vl2n_pkg::t_state r_state, n_state;
    logic [2:0]  r_iter;
    logic [2:0]  r_itleft;
    logic [CW-1:0] r_cnt;
    logic [36:0] r_sum;
    logic        r_ovf;
    logic [29:0] r_m;
    logic [31:0] r_y;
    logic [63:0] r_t;
    logic [5:0]  r_shift;
    logic        r_zero;
    logic [CW-1:0] r_ridx;
    logic        r_rvld, r_rlast, r_rtrunc;

    logic        acc;
    logic [15:0] mag;
    logic [37:0] sum_n;
    logic [5:0]  p;
    logic [31:0] mul_a;
    logic [33:0] mul_b;
    logic [65:0] prod;
    logic [63:0] dval;
    logic [15:0] rdata;

    assign busy = (r_state != vl2n_pkg::ST_LOAD);
    assign acc  = start && !busy;
    assign mag  = i_element[15] ? 16'(-i_element) : i_element;
    assign sum_n = 38'(r_sum) + 38'(32'(mag) * 32'(mag));

    // Position of the top set bit of the sum.
    always_comb begin
        p = '0;
        for (int j = 0; j < 37; j++) begin
            if (r_sum[j]) begin
                p = 6'(j);
            end
        end
    end

    // The one shared multiplier of the Newton unit.
    always_comb begin
        mul_a = r_y;
        mul_b = 34'(r_y);
        case (r_state)
            vl2n_pkg::ST_NMUL: begin
                mul_a = 32'(r_m);
                mul_b = 34'(r_t >> 30);
            end
            vl2n_pkg::ST_NUPD: begin
                mul_a = r_y;
                mul_b = dval[33:0];
            end
            default: ;
        endcase
        prod = mul_a * mul_b;
    end
    assign dval = ((r_t >> 30) >= (64'd3 << 30)) ? 64'd0 : ((64'd3 << 30) - (r_t >> 30));

    always_comb begin
        n_state = r_state;
        case (r_state)
            vl2n_pkg::ST_LOAD: if (acc && i_last) n_state = vl2n_pkg::ST_NORM;
            vl2n_pkg::ST_NORM: n_state = vl2n_pkg::ST_SEED;
            vl2n_pkg::ST_SEED:
                n_state = (r_zero || r_iter == 3'd0) ? vl2n_pkg::ST_EMIT : vl2n_pkg::ST_NSQ;
            vl2n_pkg::ST_NSQ:  n_state = vl2n_pkg::ST_NMUL;
            vl2n_pkg::ST_NMUL: n_state = vl2n_pkg::ST_NUPD;
            vl2n_pkg::ST_NUPD:
                n_state = (r_itleft == 3'd1) ? vl2n_pkg::ST_EMIT : vl2n_pkg::ST_NSQ;
            vl2n_pkg::ST_EMIT:
                if (r_ridx + CW'(1) >= r_cnt) n_state = vl2n_pkg::ST_LOAD;
            default: n_state = vl2n_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vl2n_pkg::ST_LOAD;
            r_iter  <= vl2n_pkg::ItReset;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
            r_rvld  <= 1'b0;
            r_ridx  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_iter <= i_cfg_data;
            r_rvld <= (r_state == vl2n_pkg::ST_EMIT) && (r_cnt != '0);
            case (r_state)
                vl2n_pkg::ST_LOAD: begin
                    r_ridx <= '0;
                    if (acc) begin
                        if (r_cnt < CW'(MAX_LEN)) begin
                            r_cnt <= r_cnt + CW'(1);
                            r_sum <= sum_n[37] ? {37{1'b1}} : sum_n[36:0];
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                vl2n_pkg::ST_EMIT: begin
                    r_ridx <= r_ridx + CW'(1);
                    if (n_state == vl2n_pkg::ST_LOAD) begin
                        r_cnt <= '0;
                        r_sum <= '0;
                        r_ovf <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers of the inverse-root unit, plus the last and overflow flags of the read path.
    always_ff @(posedge i_clk) begin
        r_rlast  <= (r_ridx + CW'(1) == r_cnt);
        // The overflow flag clears with the last read, so it travels with the data.
        r_rtrunc <= r_ovf;
        case (r_state)
            vl2n_pkg::ST_NORM: begin
                r_zero <= (r_sum == '0);
                if (p[0]) begin
                    r_shift <= 6'(6'sd29 - 6'(p));
                    r_m <= (p <= 6'd29) ? 30'(r_sum << (6'd29 - p)) : 30'(r_sum >> (p - 6'd29));
                end else begin
                    r_shift <= 6'(6'sd28 - 6'(p));
                    r_m <= (p <= 6'd28) ? 30'(r_sum << (6'd28 - p)) : 30'(r_sum >> (p - 6'd28));
                end
            end
            vl2n_pkg::ST_SEED: begin
                r_y <= r_zero ? 32'd0 : seed_tab[r_m[29 -: SEED_BITS]];
                r_itleft <= r_iter;
                // Output right shift: 27 - (sh - 6)/2 with sh even.
                r_shift <= 6'(6'sd30 - 6'($signed(r_shift) >>> 1));
            end
            vl2n_pkg::ST_NSQ:  r_t <= prod[63:0];
            vl2n_pkg::ST_NMUL: r_t <= prod[63:0];
            vl2n_pkg::ST_NUPD: begin
                r_y <= (prod[65:63] != 3'd0) ? 32'hFFFF_FFFF : prod[62:31];
                r_itleft <= r_itleft - 3'd1;
            end
            default: ;
        endcase
    end

    vl2n_store #(.MAX_LEN(MAX_LEN), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (acc && (r_cnt < CW'(MAX_LEN))),
        .i_waddr (AW'(r_cnt)),
        .i_wdata (i_element),
        .i_raddr (AW'(r_ridx)),
        .o_rdata (rdata)
    );

    vl2n_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rvld),
        .i_elem  (rdata),
        .i_y     (r_y),
        .i_shift (r_shift),
        .i_zero  (r_zero),
        .i_last  (r_rlast),
        .i_trunc (r_rtrunc),
        .o_vld   (o_strobe),
        .o_data  (o_norm_element),
        .o_last  (o_last_res),
        .o_zero  (o_zero_vector),
        .o_trunc (o_truncated)
    );
endmodule

// ===== rtl/core/vl2n_checker.sv =====
// Port-level checks for the L2 vector normalizer, bound to the top level.
// Depends only on the top level's ports.
module vl2n_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_last,
    input logic        o_strobe,
    input logic [15:0] o_norm_element,
    input logic        o_zero_vector
);
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_zero_vector |-> o_norm_element == 16'd0)
        else $error("zero vector item not zero");
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last |=> busy)
        else $error("busy did not rise after final item");
    a_no_strobe_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && $past(!busy) && $past(!busy, 2) && $past(!busy, 3) |-> !o_strobe)
        else $error("result while loading");
endmodule

bind vector_l2_normalizer_unit vl2n_checker u_vl2n_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_last         (i_last),
    .o_strobe       (o_strobe),
    .o_norm_element (o_norm_element),
    .o_zero_vector  (o_zero_vector)
);
